/* sv/pcrc_pkg.sv */
// Shared widths, register indexes, mode codes and reset values of the checksum block.
package pcrc_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 32;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CHECK_W     = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned WIDTH_CFG_W = 6;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [MODE_W-1:0]      mode_type;

   localparam csr_index_type CSR_MODE        = 3'd0;
   localparam csr_index_type CSR_CRC_WIDTH   = 3'd1;
   localparam csr_index_type CSR_CRC_POLY    = 3'd2;
   localparam csr_index_type CSR_CRC_INIT    = 3'd3;
   localparam csr_index_type CSR_REFLECT_IN  = 3'd4;
   localparam csr_index_type CSR_REFLECT_OUT = 3'd5;
   localparam csr_index_type CSR_XOR_OUT     = 3'd6;

   localparam mode_type MODE_FOLD = 2'd0;
   localparam mode_type MODE_SUM  = 2'd1;
   localparam mode_type MODE_CRC  = 2'd2;

   localparam mode_type                 MODE_RESET        = MODE_CRC;
   localparam logic [WIDTH_CFG_W-1:0]   CRC_WIDTH_RESET   = 6'd32;
   localparam logic [CSR_DATA_W-1:0]    CRC_POLY_RESET    = 32'h04C1_1DB7;
   localparam logic [CSR_DATA_W-1:0]    CRC_INIT_RESET    = 32'hFFFF_FFFF;
   localparam logic                     REFLECT_IN_RESET  = 1'b1;
   localparam logic                     REFLECT_OUT_RESET = 1'b1;
   localparam logic [CSR_DATA_W-1:0]    XOR_OUT_RESET     = 32'hFFFF_FFFF;

   localparam int unsigned MIN_WIDTH = 8;

   function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = b[BYTE_W-1-i];
      end
      return r;
   endfunction

endpackage

/* sv/parameterized_crc_checksum.sv */
// Datapath: an accepted request is held in the input register, and a last byte's result then
// goes to the result register, given the result register is free or being taken.
// Throughput: one byte per cycle while a last byte is not held by a full result register; set by
// the eight-step CRC feedback chain that closes through the running register.
// Reset: synchronous; clears the pipeline, zeroes the running register and loads the
// configuration defaults (standard reflected 32-bit CRC).
module parameterized_crc_checksum #(
   parameter int unsigned MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pcrc_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                               req_tuser,   // [0] first_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pcrc_pkg::CHECK_W-1:0]       rsp_tdata,   // [31:0] check_value
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcrc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcrc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pcrc_pkg::*;

   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

   typedef logic [MAX_WIDTH-1:0] word_type;
   typedef logic [WW-1:0]        wcnt_type;

   mode_type                 mode_ff;
   logic [WIDTH_CFG_W-1:0]   width_ff;
   word_type                 poly_ff;
   word_type                 init_ff;
   logic                     refin_ff;
   logic                     refout_ff;
   word_type                 xorout_ff;

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     in_first_ff;
   logic                     in_last_ff;

   word_type                 run_ff;
   word_type                 run_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   word_type                 rsp_data_ff;
   word_type                 rsp_data_in;

   wcnt_type                 eff_w;
   wcnt_type                 pad;
   word_type                 mask;
   word_type                 top_mask;
   word_type                 start;
   word_type                 crc;
   word_type                 rev;
   word_type                 refl;
   logic [BYTE_W-1:0]        din;
   logic                     advance;

   always_comb begin
      if (width_ff < WIDTH_CFG_W'(MIN_WIDTH)) begin
         eff_w = wcnt_type'(MIN_WIDTH);
      end else if (width_ff > WIDTH_CFG_W'(MAX_WIDTH)) begin
         eff_w = wcnt_type'(MAX_WIDTH);
      end else begin
         eff_w = wcnt_type'(width_ff);
      end
   end

   assign mask     = ~({MAX_WIDTH{1'b1}} << eff_w);
   assign top_mask = word_type'(1) << (eff_w - wcnt_type'(1));
   assign pad      = wcnt_type'(MAX_WIDTH) - eff_w;

   // update the running register for the held request
   always_comb begin
      start = run_ff & mask;
      if (in_first_ff) begin
         start = (mode_ff == MODE_CRC) ? (init_ff & mask) : '0;
      end
      din = refin_ff ? reverse_byte(in_byte_ff) : in_byte_ff;
      crc = start ^ (word_type'(din) << (eff_w - wcnt_type'(MIN_WIDTH)));
      for (int i = 0; i < BYTE_W; i++) begin
         if (|(crc & top_mask)) begin
            crc = ((crc << 1) ^ poly_ff) & mask;
         end else begin
            crc = (crc << 1) & mask;
         end
      end
      case (mode_ff)
         MODE_FOLD: run_in = ((start ^ (start << BYTE_W)) ^ word_type'(in_byte_ff)) & mask;
         MODE_SUM:  run_in = (start + word_type'(in_byte_ff)) & mask;
         MODE_CRC:  run_in = crc;
         default:   run_in = start;
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         rev[i] = run_in[MAX_WIDTH-1-i];
      end
      refl = refout_ff ? (rev >> pad) : run_in;
      if (mode_ff == MODE_CRC) begin
         rsp_data_in = (refl ^ xorout_ff) & mask;
      end else begin
         rsp_data_in = run_in;
      end
   end

   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = (advance && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = CHECK_W'(rsp_data_ff);
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= CRC_WIDTH_RESET;
         poly_ff   <= word_type'(CRC_POLY_RESET);
         init_ff   <= word_type'(CRC_INIT_RESET);
         refin_ff  <= REFLECT_IN_RESET;
         refout_ff <= REFLECT_OUT_RESET;
         xorout_ff <= word_type'(XOR_OUT_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff   <= csr_data[MODE_W-1:0];
            CSR_CRC_WIDTH:   width_ff  <= csr_data[WIDTH_CFG_W-1:0];
            CSR_CRC_POLY:    poly_ff   <= csr_data[MAX_WIDTH-1:0];
            CSR_CRC_INIT:    init_ff   <= csr_data[MAX_WIDTH-1:0];
            CSR_REFLECT_IN:  refin_ff  <= csr_data[0];
            CSR_REFLECT_OUT: refout_ff <= csr_data[0];
            CSR_XOR_OUT:     xorout_ff <= csr_data[MAX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            run_ff <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("last request advanced without a response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !(advance && in_last_ff)) |=> !rsp_valid_ff)
      else $error("response raised without a last request");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_first_ff) && $stable(in_last_ff)))
      else $error("stalled request lost or changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without a full response register");

endmodule

/* sim/tb_parameterized_crc_checksum.sv */
// Self-checking testbench for the parameterised CRC and checksum block with random flow control.
module tb_parameterized_crc_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   import pcrc_pkg::*;

   localparam int unsigned DUT_MAX_WIDTH = MAX_WIDTH_DEFAULT;
   localparam int unsigned ITEM_TARGET   = 1950;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned HOLD_CYCLES   = 250;

   localparam mode_type      MODE_SPARE = 2'd3;
   localparam csr_index_type CSR_SPARE  = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              last;
   } byte_req_type;

   typedef struct packed {
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] value;
   } csr_write_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [CHECK_W-1:0]     rsp_tdata;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   byte_req_type       pending_bytes[$];
   csr_write_type      csr_pending[$];
   logic [CHECK_W-1:0] expected_checks[$];

   mode_type               cfg_mode;
   logic [WIDTH_CFG_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0]  cfg_poly;
   logic [CSR_DATA_W-1:0]  cfg_init;
   logic                   cfg_refin;
   logic                   cfg_refout;
   logic [CSR_DATA_W-1:0]  cfg_xorout;
   logic [CHECK_W-1:0]     running_check;

   int unsigned bytes_queued   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned config_writes  = 0;
   int unsigned mismatches     = 0;
   int unsigned req_gap        = 0;
   int unsigned req_quiet      = 0;
   int unsigned rsp_stall      = 0;
   int unsigned rsp_quiet      = 0;
   int unsigned rsp_hold       = 0;
   int unsigned idle_cycles    = 0;

   parameterized_crc_checksum #(.MAX_WIDTH(DUT_MAX_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] mirror(input logic [31:0] v, input int unsigned n);
      logic [31:0] r;
      r = '0;
      for (int unsigned i = 0; i < n; i++) r[i] = v[n-1-i];
      return r;
   endfunction

   // Advance the running register by one byte; returns 1 when a check value is due.
   function automatic bit checksum_step(input logic [BYTE_W-1:0] data, input logic first,
                                        input logic last, output logic [CHECK_W-1:0] check);
      int unsigned w;
      logic [31:0] mask;
      logic [31:0] acc;
      logic [31:0] feed;
      w = (cfg_width < MIN_WIDTH) ? MIN_WIDTH :
          ((cfg_width > DUT_MAX_WIDTH) ? DUT_MAX_WIDTH : int'(cfg_width));
      mask = 32'((64'd1 << w) - 64'd1);
      acc = running_check & mask;
      if (first) acc = (cfg_mode == MODE_CRC) ? (cfg_init & mask) : '0;
      case (cfg_mode)
         MODE_FOLD: acc = (acc ^ (acc << 8) ^ 32'(data)) & mask;
         MODE_SUM:  acc = (acc + 32'(data)) & mask;
         MODE_CRC: begin
            feed = cfg_refin ? mirror(32'(data), BYTE_W) : 32'(data);
            acc  = acc ^ (feed << (w - BYTE_W));
            for (int i = 0; i < BYTE_W; i++) begin
               acc = acc[w-1] ? ((acc << 1) ^ cfg_poly) : (acc << 1);
               acc = acc & mask;
            end
         end
         default: ;
      endcase
      running_check = acc;
      if (cfg_mode == MODE_CRC) check = ((cfg_refout ? mirror(acc, w) : acc) ^ cfg_xorout) & mask;
      else check = acc & mask;
      return last;
   endfunction

   function automatic int unsigned next_gap(ref int unsigned quiet);
      int unsigned roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 199);
      if (roll == 0) begin
         quiet = $urandom_range(40, 250);
         return 0;
      end
      if (roll < 110) return 0;
      if (roll < 180) return $urandom_range(1, 3);
      if (roll < 196) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : byte_driver
      byte_req_type       next_req;
      logic [CHECK_W-1:0] predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
         running_check = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (checksum_step(req_tdata, req_tuser, req_tlast, predicted))
               expected_checks.push_back(predicted);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_req = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_req.data;
               req_tuser  <= next_req.first;
               req_tlast  <= next_req.last;
               req_gap = next_gap(req_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_monitor
      logic [CHECK_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_checks.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected check value %08h", rsp_tdata);
            end else begin
               want = expected_checks.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("check value mismatch: expected %08h, got %08h", want, rsp_tdata);
               end
            end
            // hold off long enough for the block to back up into the request side
            if (results_seen % 100 == 50) rsp_hold = HOLD_CYCLES;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = next_gap(rsp_quiet);
         end
      end
   end

   always @(posedge clock) begin : csr_driver
      csr_write_type next_write;
      if (reset) begin
         csr_valid  <= 1'b0;
         cfg_mode   = MODE_RESET;
         cfg_width  = CRC_WIDTH_RESET;
         cfg_poly   = CRC_POLY_RESET;
         cfg_init   = CRC_INIT_RESET;
         cfg_refin  = REFLECT_IN_RESET;
         cfg_refout = REFLECT_OUT_RESET;
         cfg_xorout = XOR_OUT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:        cfg_mode   = csr_data[MODE_W-1:0];
               CSR_CRC_WIDTH:   cfg_width  = csr_data[WIDTH_CFG_W-1:0];
               CSR_CRC_POLY:    cfg_poly   = csr_data;
               CSR_CRC_INIT:    cfg_init   = csr_data;
               CSR_REFLECT_IN:  cfg_refin  = csr_data[0];
               CSR_REFLECT_OUT: cfg_refout = csr_data[0];
               CSR_XOR_OUT:     cfg_xorout = csr_data;
               default: ;
            endcase
            config_writes++;
         end
         if (!csr_valid || csr_ready) begin
            if (csr_pending.size() > 0) begin
               next_write = csr_pending.pop_front();
               csr_valid <= 1'b1;
               csr_index <= next_write.index;
               csr_data  <= next_write.value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic first, input logic last);
      pending_bytes.push_back('{data: data, first: first, last: last});
      bytes_queued++;
   endtask

   // Mostly well-formed messages; about one in ten gets random first and last marks.
   task automatic queue_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned len;
      bit          noisy;
      stop_at = bytes_queued + count;
      while (bytes_queued < stop_at) begin
         len   = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         noisy = ($urandom_range(0, 9) == 0);
         for (int unsigned i = 0; i < len; i++) begin
            if (noisy) queue_byte(8'($urandom), 1'($urandom), 1'($urandom));
            else queue_byte(8'($urandom), i == 0, i == len - 1);
         end
      end
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req_tvalid || expected_checks.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input mode_type mode, input logic [WIDTH_CFG_W-1:0] width,
                             input logic [31:0] poly, input logic [31:0] init,
                             input logic refin, input logic refout,
                             input logic [31:0] xorout, input bit with_spare);
      drain();
      if (with_spare) csr_pending.push_back('{CSR_SPARE, $urandom});
      csr_pending.push_back('{CSR_MODE, 32'(mode)});
      csr_pending.push_back('{CSR_CRC_WIDTH, 32'(width)});
      csr_pending.push_back('{CSR_CRC_POLY, poly});
      csr_pending.push_back('{CSR_CRC_INIT, init});
      csr_pending.push_back('{CSR_REFLECT_IN, 32'(refin)});
      csr_pending.push_back('{CSR_REFLECT_OUT, 32'(refout)});
      csr_pending.push_back('{CSR_XOR_OUT, xorout});
      while (csr_pending.size() > 0 || csr_valid) @(negedge clock);
   endtask

   initial begin : stimulus
      mode_type mode;
      int unsigned roll;
      string check_msg;
      check_msg = "123456789";
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: reflected 32-bit CRC
      queue_byte(8'h80, 1'b0, 1'b1);
      queue_byte(8'h5A, 1'b0, 1'b1);
      for (int i = 0; i < check_msg.len(); i++)
         queue_byte(check_msg[i], i == 0, i == check_msg.len() - 1);
      queue_byte(8'h00, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b1, 1'b1);
      queue_byte(8'h3C, 1'b1, 1'b0);
      queue_byte(8'hC3, 1'b1, 1'b0);
      queue_byte(8'hA5, 1'b0, 1'b1);

      set_config(MODE_FOLD, 6'd45, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      queue_traffic(40);
      set_config(MODE_SUM, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_traffic(40);
      set_config(MODE_SPARE, 6'd20, 32'h0, 32'h1234_5678, 1'b0, 1'b1, 32'h0, 1'b0);
      queue_traffic(40);
      set_config(MODE_CRC, 6'd0, 32'h0000_00FF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_traffic(40);
      set_config(MODE_CRC, 6'd63, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0);
      queue_traffic(40);
      set_config(MODE_CRC, 6'd16, 32'h0000_8005, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0);
      queue_traffic(40);
      set_config(MODE_CRC, 6'd8, 32'h0000_0007, 32'h0, 1'b0, 1'b0, 32'h0, 1'b1);
      queue_traffic(40);

      while (bytes_queued < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         mode = (roll < 6) ? MODE_CRC : (roll < 8) ? MODE_FOLD : (roll < 9) ? MODE_SUM : MODE_SPARE;
         set_config(mode,
                    ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(8, 32)),
                    $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom, 1'b0);
         queue_traffic($urandom_range(100, 200));
      end

      drain();
      $display("Run covered %0d bytes, %0d check values and %0d register writes", bytes_accepted,
               results_seen, config_writes);
      $display("across fold, sum, spare and CRC modes with widths inside and outside 8..32");
      if (mismatches == 0 && expected_checks.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d check values outstanding", mismatches,
                  expected_checks.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
